### rtl/dmsl_pkg.sv
// Package for the dual motor slew limiter: types, register map, constants, angle mapping.
`default_nettype none

package dmsl_pkg;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_SLEW_STEP   = 2'd0,
        REG_LEFT_OFFSET = 2'd1,
        REG_RIGHT_GAIN  = 2'd2
    } reg_idx_t;

    localparam logic [13:0] SLEW_STEP_RST   = 14'd512;
    localparam logic [13:0] LEFT_OFFSET_RST = 14'd1280;
    localparam logic [9:0]  RIGHT_GAIN_RST  = 10'd307;

    typedef struct packed {
        logic [13:0] slew_step;
        logic [13:0] left_offset;
        logic [9:0]  right_gain;
    } cfg_t;

    // Request and result payloads
    typedef struct packed {
        logic signed [15:0] left_target;
        logic signed [15:0] right_target;
        logic               drive_disabled;
    } in_t;

    typedef struct packed {
        logic [7:0] left_command;
        logic [7:0] right_command;
    } out_t;

    // Divider: 30-bit dividend (step * smaller magnitude), one quotient bit a cycle
    localparam int DIV_N = 30;
    localparam int DIV_D = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N);

    // Angle mapping: floor(u*90/127) == (u * 90 * ceil(2^22/127)) >> 22 for u < 254
    localparam int MAP_SHIFT = 22;
    localparam logic [29:0] MAP_RECIP = 30'd2972430;
    localparam logic [7:0]  ANGLE_MAX = 8'd180;

    // Sequencer states
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MUL    = 9'b000000010,
        ST_DSTART = 9'b000000100,
        ST_DWAIT  = 9'b000001000,
        ST_STEP   = 9'b000010000,
        ST_SCALE  = 9'b000100000,
        ST_MAPL   = 9'b001000000,
        ST_MAPR   = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    // Integer speed -127..127 onto 0..180, saturated outside
    function automatic logic [7:0] map_angle(input logic signed [11:0] t);
        logic [7:0]  u;
        logic [29:0] prod;
        logic [7:0]  res;
        u    = 8'(t + 12'sd127);
        prod = 30'(u) * MAP_RECIP;
        if (t <= -12'sd127)
            res = 8'd0;
        else if (t >= 12'sd127)
            res = ANGLE_MAX;
        else
            res = prod[29:MAP_SHIFT];
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/dmsl_div.sv
// Restoring divider, one quotient bit per cycle, for the slave channel step ratio.
`default_nettype none

module dmsl_div
    import dmsl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIV_N-1:0]  dividend,
    input  wire logic [DIV_D-1:0]  divisor,
    output logic                   done,
    output logic [DIV_N-1:0]       quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_D:0]       rem_reg, rem_next;
    logic [DIV_N-1:0]     quot_reg, quot_next;
    logic [DIV_D-1:0]     dvs_reg, dvs_next;
    logic [DIV_D:0]       shifted;
    logic [DIV_D+1:0]     trial;
    logic                 ge;

    // One compare-subtract step
    always_comb
    begin
        shifted   = {rem_reg[DIV_D-1:0], quot_reg[DIV_N-1]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        ge        = ~trial[DIV_D+1];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial[DIV_D:0] : shifted;
            quot_next = {quot_reg[DIV_N-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

### rtl/dmsl_cfg.sv
// APB register file: slew step, left offset, right gain.
`default_nettype none

module dmsl_cfg
    import dmsl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg, cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SLEW_STEP:   cfg_next.slew_step   = pwdata[13:0];
                REG_LEFT_OFFSET: cfg_next.left_offset = pwdata[13:0];
                REG_RIGHT_GAIN:  cfg_next.right_gain  = pwdata[9:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slew_step   <= SLEW_STEP_RST;
            cfg_reg.left_offset <= LEFT_OFFSET_RST;
            cfg_reg.right_gain  <= RIGHT_GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_SLEW_STEP:   prdata = DATA_W'(cfg_reg.slew_step);
            REG_LEFT_OFFSET: prdata = DATA_W'(cfg_reg.left_offset);
            REG_RIGHT_GAIN:  prdata = DATA_W'(cfg_reg.right_gain);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/dual_motor_slew_limiter_unit.sv
// Top level: sequencer, shared multiplier, speed state and output register.
//
//  channel | direction | handshake          | payload
//  in      | request   | in_valid/in_stall   | in_data   (in_t)
//  out     | result    | out_valid/out_stall | out_data  (out_t)
//  apb     | config    | psel/penable/pready | paddr, pwdata, prdata
//
// A request whose target magnitudes differ runs the bit-serial divider for the smaller
// channel's step (starting, running its 30 steps and draining) between the multiply and
// the speed update; otherwise, or with the drive disabled, the divider is skipped.
// The result is loaded into the output register from the done state. in_stall is low only while idle.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset clears both current speeds and loads the register defaults.
`default_nettype none

module dual_motor_slew_limiter_unit
    import dmsl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire in_t               in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output out_t                   out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    cfg_t   cfg;
    state_t state_reg, state_next;

    logic signed [15:0] lt_reg, rt_reg;
    logic               dis_reg;
    logic [15:0]        min_reg, max_reg;
    logic               lbig_reg, rbig_reg;
    logic [13:0]        ratio_reg;
    logic signed [17:0] lspd_reg, lspd_next;
    logic signed [17:0] rspd_reg, rspd_next;
    logic signed [33:0] prod_reg;
    logic signed [11:0] lv_reg, rv_reg;
    logic [7:0]         lcmd_reg, rcmd_reg;
    logic               out_valid_reg;
    out_t               out_data_reg;

    logic [15:0]        lmag, rmag;
    logic               accept, out_take, out_load;
    logic signed [18:0] mul_a;
    logic signed [14:0] mul_b;
    logic signed [33:0] mul_p;
    logic               div_start, div_done;
    logic [DIV_N-1:0]   div_q;
    logic [13:0]        la, ra;
    logic signed [17:0] ltgt, rtgt;
    logic signed [18:0] ldiff, lbias;
    logic signed [33:0] rbias;
    logic signed [11:0] map_in;
    logic [7:0]         map_out;

    dmsl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dmsl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[DIV_N-1:0]),
        .divisor  (max_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Handshakes
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid & ~in_stall;
    assign out_take  = out_valid_reg & ~out_stall;
    assign out_load  = (state_reg == ST_DONE) & (~out_valid_reg | ~out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign div_start = (state_reg == ST_DSTART);

    // Target magnitudes
    assign lmag = in_data.left_target[15]  ? 16'(-in_data.left_target)  : in_data.left_target;
    assign rmag = in_data.right_target[15] ? 16'(-in_data.right_target) : in_data.right_target;

    // Shared multiplier: step * smaller magnitude, then right speed * gain
    always_comb
    begin
        if (state_reg == ST_SCALE)
        begin
            mul_a = {rspd_reg[17], rspd_reg};
            mul_b = {5'b00000, cfg.right_gain};
        end
        else
        begin
            mul_a = {3'b000, min_reg};
            mul_b = {1'b0, cfg.slew_step};
        end
        mul_p = mul_a * mul_b;
    end

    // Per-channel step size
    always_comb
    begin
        la = cfg.slew_step;
        ra = cfg.slew_step;
        if (lbig_reg)
            ra = ratio_reg;
        else if (rbig_reg)
            la = ratio_reg;
    end

    // Speed update, not clamped at the target
    assign ltgt = {{2{lt_reg[15]}}, lt_reg};
    assign rtgt = {{2{rt_reg[15]}}, rt_reg};

    always_comb
    begin
        if (lspd_reg > ltgt)
            lspd_next = lspd_reg - $signed({4'b0000, la});
        else if (lspd_reg < ltgt)
            lspd_next = lspd_reg + $signed({4'b0000, la});
        else
            lspd_next = lspd_reg;
        if (rspd_reg > rtgt)
            rspd_next = rspd_reg - $signed({4'b0000, ra});
        else if (rspd_reg < rtgt)
            rspd_next = rspd_reg + $signed({4'b0000, ra});
        else
            rspd_next = rspd_reg;
    end

    // Truncation toward zero: left by 256, right by 65536
    assign ldiff = {lspd_reg[17], lspd_reg} - $signed({5'b00000, cfg.left_offset});
    assign lbias = ldiff + (ldiff[18] ? 19'sd255 : 19'sd0);
    assign rbias = prod_reg + (prod_reg[33] ? 34'sd65535 : 34'sd0);

    // Shared angle mapper
    assign map_in  = (state_reg == ST_MAPL) ? lv_reg : rv_reg;
    assign map_out = map_angle(map_in);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_MUL;
            ST_MUL:    state_next = (!dis_reg && (lbig_reg || rbig_reg)) ? ST_DSTART : ST_STEP;
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:  if (div_done) state_next = ST_STEP;
            ST_STEP:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_MAPL;
            ST_MAPL:   state_next = ST_MAPR;
            ST_MAPR:   state_next = ST_DONE;
            ST_DONE:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state and current speeds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            lspd_reg      <= '0;
            rspd_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_STEP)
            begin
                if (dis_reg)
                begin
                    lspd_reg <= '0;
                    rspd_reg <= '0;
                end
                else
                begin
                    lspd_reg <= lspd_next;
                    rspd_reg <= rspd_next;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lt_reg   <= in_data.left_target;
            rt_reg   <= in_data.right_target;
            dis_reg  <= in_data.drive_disabled;
            min_reg  <= (lmag > rmag) ? rmag : lmag;
            max_reg  <= (lmag > rmag) ? lmag : rmag;
            lbig_reg <= (lmag > rmag);
            rbig_reg <= (lmag < rmag);
        end
        if (state_reg == ST_MUL || state_reg == ST_SCALE)
            prod_reg <= mul_p;
        if (state_reg == ST_DWAIT && div_done)
            ratio_reg <= div_q[13:0];
        if (state_reg == ST_SCALE)
            lv_reg <= {lbias[18], lbias[18:8]};
        if (state_reg == ST_MAPL)
        begin
            rv_reg   <= rbias[27:16];
            lcmd_reg <= map_out;
        end
        if (state_reg == ST_MAPR)
            rcmd_reg <= map_out;
        if (out_load)
        begin
            out_data_reg.left_command  <= lcmd_reg;
            out_data_reg.right_command <= rcmd_reg;
        end
    end

    // Checks
    a_div_needs_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DSTART) |-> (max_reg != 16'd0 && !dis_reg))
        else $error("divider started with zero divisor or while disabled");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DWAIT))
        else $error("divider finished outside the wait state");

    a_disable_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && dis_reg) |=> (lspd_reg == 18'sd0 && rspd_reg == 18'sd0))
        else $error("disabled request did not clear speeds");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MUL && !out_load))
        else $error("accepted request did not start the sequence");

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the dual motor slew limiter unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dmsl_pkg::*;

    // Command predictor and store of the commands still owed by the block
    class slew_board;
        int slew_step;
        int left_offset;
        int right_gain;
        int left_now;
        int right_now;
        out_t expected_cmds[$];
        int n_requests;
        int n_checked;
        int n_errors;

        function new();
            slew_step = SLEW_STEP_RST;
            left_offset = LEFT_OFFSET_RST;
            right_gain = RIGHT_GAIN_RST;
            left_now = 0;
            right_now = 0;
        endfunction

        function void report(string msg);
            n_errors++;
            if (n_errors <= 10)
                $display("[%0t] MISMATCH %s", $realtime, msg);
        endfunction

        function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] v);
            case (idx)
                REG_SLEW_STEP:   slew_step = v[13:0];
                REG_LEFT_OFFSET: left_offset = v[13:0];
                REG_RIGHT_GAIN:  right_gain = v[9:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] reg_value(reg_idx_t idx);
            case (idx)
                REG_SLEW_STEP:   return slew_step;
                REG_LEFT_OFFSET: return left_offset;
                REG_RIGHT_GAIN:  return right_gain;
                default:         return '0;
            endcase
        endfunction

        // Speeds live in 18 bits, two's complement
        function int wrap18(longint v);
            logic signed [17:0] w;
            w = v[17:0];
            return int'(w);
        endfunction

        // No clamp at the target: the speed may overshoot by less than a step
        function int advance(int now, int target, longint delta);
            if (now > target)
                return wrap18(longint'(now) - delta);
            if (now < target)
                return wrap18(longint'(now) + delta);
            return now;
        endfunction

        // -127..127 onto 0..180, division truncating toward zero, then saturate
        function logic [7:0] servo_angle(longint t);
            longint m;
            m = ((t + 127) * 180) / 254;
            if (m < 0)
                m = 0;
            if (m > 180)
                m = 180;
            return m[7:0];
        endfunction

        function void note_request(in_t req);
            longint lt;
            longint rt;
            longint lmag;
            longint rmag;
            longint l_add;
            longint r_add;
            longint lv;
            longint rv;
            out_t cmd;
            n_requests++;
            lt = longint'(req.left_target);
            rt = longint'(req.right_target);
            if (req.drive_disabled)
            begin
                left_now = 0;
                right_now = 0;
                cmd.left_command = servo_angle(-longint'(left_offset) / 256);
                cmd.right_command = servo_angle(0);
            end
            else
            begin
                lmag = (lt < 0) ? -lt : lt;
                rmag = (rt < 0) ? -rt : rt;
                l_add = slew_step;
                r_add = slew_step;
                // smaller channel gets a proportionally smaller step
                if (lmag > rmag)
                    r_add = (longint'(slew_step) * rmag) / lmag;
                else if (lmag < rmag)
                    l_add = (longint'(slew_step) * lmag) / rmag;
                left_now = advance(left_now, int'(lt), l_add);
                right_now = advance(right_now, int'(rt), r_add);
                lv = (longint'(left_now) - longint'(left_offset)) / 256;
                rv = (longint'(right_now) * longint'(right_gain)) / 65536;
                cmd.left_command = servo_angle(lv);
                cmd.right_command = servo_angle(rv);
            end
            expected_cmds.push_back(cmd);
        endfunction

        function void check_command(out_t got);
            out_t want;
            n_checked++;
            if (expected_cmds.size() == 0)
            begin
                report($sformatf("result #%0d with nothing expected: left %0d right %0d",
                                 n_checked, got.left_command, got.right_command));
                return;
            end
            want = expected_cmds.pop_front();
            if (got.left_command !== want.left_command)
                report($sformatf("result #%0d left_command: expected %0d, got %0d",
                                 n_checked, want.left_command, got.left_command));
            if (got.right_command !== want.right_command)
                report($sformatf("result #%0d right_command: expected %0d, got %0d",
                                 n_checked, want.right_command, got.right_command));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    in_t               in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    out_t              out_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    slew_board board;
    int  n_sent = 0;
    int  n_directed = 0;
    int  n_settings = 1;
    logic long_hold = 1'b0;
    bit  rx_busy = 1'b0;
    int  rx_run = 0;

    dual_motor_slew_limiter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #(20_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // Sender gap: mostly back to back or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(40, 120);
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic int free_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 12);
        return $urandom_range(40, 150);
    endfunction

    // Result side: take commands, alternate free and stalled runs
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_command(out_data);
        if (rx_run == 0)
        begin
            rx_busy = !rx_busy;
            rx_run = rx_busy ? stall_len() : free_len();
        end
        rx_run--;
        out_stall <= long_hold || rx_busy;
    end

    // One long receiver hold-off mid-run so the block backs up into the sender
    initial
    begin
        wait (n_sent >= 320);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (500) @(posedge clk);
        long_hold <= 1'b0;
    end

    function automatic logic signed [15:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 16'(int'($urandom_range(0, 65024)) - 32512);
        if (r < 70)
            return 16'(int'($urandom_range(0, 1024)) - 512);
        if (r < 85)
        begin
            case ($urandom_range(0, 4))
                0:       return 16'sd32512;
                1:       return -16'sd32512;
                2:       return 16'sh7fff;
                3:       return 16'sh8000;
                default: return 16'sd0;
            endcase
        end
        return 16'($urandom);
    endfunction

    // Targets mostly held for a while so the speeds ramp, settle and overshoot
    function automatic in_t make_request(in_t prev);
        in_t req;
        int r;
        req = prev;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            // both targets held
        end
        else if (r < 83)
        begin
            req.left_target = pick_target();
            req.right_target = $urandom_range(0, 1) ? req.left_target : -req.left_target;
        end
        else if (r < 93)
        begin
            req.left_target = pick_target();
            req.right_target = pick_target();
        end
        else if ($urandom_range(0, 1))
            req.left_target = pick_target();
        else
            req.right_target = pick_target();
        req.drive_disabled = ($urandom_range(0, 99) < 6);
        return req;
    endfunction

    task automatic send_request(in_t req);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(req);
        n_sent++;
    endtask

    task automatic send_pair(int lt, int rt, bit dis);
        in_t req;
        req.left_target = 16'(lt);
        req.right_target = 16'(rt);
        req.drive_disabled = dis;
        send_request(req);
        n_directed++;
    endtask

    // One APB transfer: setup phase, access phase until pready, then back to idle
    task automatic reg_access(reg_idx_t idx, bit wr, logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(reg_idx_t idx);
        logic [DATA_W-1:0] rd;
        reg_access(idx, 1'b0, '0, rd);
        if (rd !== board.reg_value(idx))
            board.report($sformatf("readback of %s: expected %0d, got %0d",
                                   idx.name(), board.reg_value(idx), rd));
    endtask

    task automatic write_reg(reg_idx_t idx, int v);
        logic [DATA_W-1:0] rd;
        reg_access(idx, 1'b1, v, rd);
        board.set_reg(idx, v);
        check_reg(idx);
    endtask

    task automatic apply_config(int step, int offset, int gain);
        write_reg(REG_SLEW_STEP, step);
        write_reg(REG_LEFT_OFFSET, offset);
        write_reg(REG_RIGHT_GAIN, gain);
        n_settings++;
    endtask

    task automatic wait_drained();
        while (board.expected_cmds.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        in_t req;
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults after reset
        check_reg(REG_SLEW_STEP);
        check_reg(REG_LEFT_OFFSET);
        check_reg(REG_RIGHT_GAIN);

        // Directed: both zero, field extremes, equal magnitudes, overshoot, disabled
        send_pair(0, 0, 1'b0);
        repeat (3) send_pair(32512, 0, 1'b0);
        send_pair(0, -32512, 1'b0);
        send_pair(-32512, -32512, 1'b0);
        send_pair(32767, -32768, 1'b0);
        send_pair(-32768, 32767, 1'b0);
        send_pair(1000, -1000, 1'b0);
        repeat (2) send_pair(100, 50, 1'b0);
        send_pair(-1, 1, 1'b0);
        send_pair(1, 2, 1'b0);
        send_pair(12345, -23456, 1'b1);
        repeat (3) send_pair(32512, 32512, 1'b0);
        send_pair(0, 0, 1'b1);
        send_pair(-32512, 16256, 1'b0);
        send_pair(256, -128, 1'b0);
        send_pair(-32768, -32768, 1'b0);

        // Random phases, each under its own register setting
        req = '0;
        for (int p = 0; p < 8; p++)
        begin
            if (p > 0)
            begin
                in_valid <= 1'b0;
                wait_drained();
                case (p)
                    1: apply_config(16383, 16383, 1023);
                    2: apply_config(0, 0, 0);
                    3: apply_config(8192, 8192, 512);
                    4: apply_config(1, 1, 256);
                    default: apply_config($urandom_range(16, 4096), $urandom_range(0, 16383),
                                          $urandom_range(0, 1023));
                endcase
            end
            for (int k = 0; k < 200; k++)
            begin
                req = make_request(req);
                send_request(req);
            end
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (60) @(posedge clk);
        if (board.expected_cmds.size() > 0)
            board.report($sformatf("%0d commands never arrived", board.expected_cmds.size()));

        $display("Run covered %0d requests (%0d directed) over %0d register settings,",
                 n_sent, n_directed, n_settings);
        $display("incl. zero and full-width step/offset/gain; %0d commands checked, %0d errors.",
                 board.n_checked, board.n_errors);
        if (board.n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
